### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the correction step statistics RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

### sv/csst_pkg.sv
// ----------------------------------------------------------------------------
// Correction step statistics package
// Sequencer types, scaler interface structs and fixed-point weight constants.
// ----------------------------------------------------------------------------
package csst_pkg;

   // Main sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_DIFF,
      ST_GO,
      ST_WAIT,
      ST_OUT
   } seq_state_type;

   // Average being updated by the shared scaler.
   typedef enum logic [2:0] {
      OP_SQ100,
      OP_SQ1K,
      OP_SQ10K,
      OP_SQ100K,
      OP_STEP,
      OP_IVL
   } op_type;

   // Scaler phases.
   typedef enum logic [1:0] {
      SC_IDLE,
      SC_LO,
      SC_HI,
      SC_SUM
   } scale_state_type;

   // Command to the scaler: start a job, plain product or weighted scaling.
   typedef struct packed {
      logic start;
      logic square;
   } scale_cmd_type;

   // Scaler status back to the sequencer.
   typedef struct packed {
      logic done;
      logic busy;
   } scale_status_type;

   // Weights as round(w * 2^32).
   localparam logic [31:0] W_100  = 32'd42949673;
   localparam logic [31:0] W_1K   = 32'd4294967;
   localparam logic [31:0] W_10K  = 32'd429497;
   localparam logic [31:0] W_100K = 32'd42950;
   localparam logic [31:0] W_005  = 32'd214748365;

   localparam logic [31:0] GAP_LIMIT_MS = 32'd600000;
   localparam logic [15:0] STEP_LIMIT   = 16'hFFFF;
   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
   localparam logic [64:0] ROUND_HALF   = 65'h0_8000_0000;
   localparam int          IVL_FRAC     = 8;

endpackage

### sv/csst_scaler.sv
// ----------------------------------------------------------------------------
// Correction step statistics scaler
// Shared 32x32 multiplier computing a plain product or a rounded weighted
// fraction floor((mag * w + 2^31) / 2^32) over two multiplier passes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csst_scaler #(
   parameter int MAG_W = 56
) (
   input  logic                       clock,
   input  logic                       reset,
   input  csst_pkg::scale_cmd_type    cmd,
   input  logic [MAG_W-1:0]           cmd_mag,
   input  logic [31:0]                cmd_weight,
   output csst_pkg::scale_status_type status,
   output logic [MAG_W-1:0]           result
);

   csst_pkg::scale_state_type state_ff, state_in;
   logic                      done_ff, done_in;
   logic [MAG_W-1:0]          mag_ff;
   logic [31:0]               weight_ff;
   logic                      square_ff;
   logic [63:0]               prod_ff;
   logic [32:0]               round_ff;
   logic [MAG_W-1:0]          result_ff;
   logic [31:0]               mul_a;
   logic [63:0]               product;

   // The one multiplier: low half of the magnitude first, high half second.
   assign mul_a   = (state_ff == csst_pkg::SC_HI) ? 32'(mag_ff >> 32) : mag_ff[31:0];
   assign product = 64'(mul_a) * 64'(weight_ff);

   // Phase sequencing.
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      case (state_ff)
         csst_pkg::SC_IDLE: begin
            if (cmd.start) state_in = csst_pkg::SC_LO;
         end
         csst_pkg::SC_LO: begin
            state_in = csst_pkg::SC_HI;
         end
         csst_pkg::SC_HI: begin
            if (square_ff) begin
               state_in = csst_pkg::SC_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = csst_pkg::SC_SUM;
            end
         end
         csst_pkg::SC_SUM: begin
            state_in = csst_pkg::SC_IDLE;
            done_in  = 1'b1;
         end
         default: begin
            state_in = csst_pkg::SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csst_pkg::SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Operand capture, partial products and the final sum.
   always_ff @(posedge clock) begin
      case (state_ff)
         csst_pkg::SC_IDLE: begin
            if (cmd.start) begin
               mag_ff    <= cmd_mag;
               weight_ff <= cmd_weight;
               square_ff <= cmd.square;
            end
         end
         csst_pkg::SC_LO: begin
            prod_ff <= product;
         end
         csst_pkg::SC_HI: begin
            if (square_ff) begin
               result_ff <= MAG_W'(prod_ff);
            end else begin
               round_ff <= 33'((65'(prod_ff) + csst_pkg::ROUND_HALF) >> 32);
               prod_ff  <= product;
            end
         end
         csst_pkg::SC_SUM: begin
            result_ff <= MAG_W'(prod_ff) + MAG_W'(round_ff);
         end
         default: begin
         end
      endcase
   end

   assign status.done = done_ff;
   assign status.busy = (state_ff != csst_pkg::SC_IDLE);
   assign result      = result_ff;

   // A plain product signals done after the low and high phases of its start.
   `ASSERT_IMPL(a_square_latency, clock, reset, cmd.start && cmd.square && !status.busy, ##3 status.done, "scaler product late")
   // A weighted scaling signals done after the low, high and sum phases of its start.
   `ASSERT_IMPL(a_scale_latency, clock, reset, cmd.start && !cmd.square && !status.busy, ##4 status.done, "scaler scaling late")
   // Done is a single-cycle pulse.
   `ASSERT_NEXT(a_done_pulse, clock, reset, status.done, !status.done, "scaler done held")

endmodule

### sv/correction_step_statistics.sv
// ----------------------------------------------------------------------------
// Correction step statistics
// Running mean squares, mean, peak and interval statistics of DAC steps.
// ----------------------------------------------------------------------------
// Usage:
//  Each request word carries a DAC word (req_pwm), the gate flag (req_counting)
//  and a millisecond stamp (req_time_ms). Every accepted word yields exactly one
//  response word with all statistics as they stand after that word.
//  Words move on valid/stall handshakes; a word is taken at a rising edge with
//  valid high and stall low. The block works on one request word at a time and
//  holds req_stall high until that word's response is in the output register.
//  With the gate closed a word goes straight to the output stage. A counted step
//  uses the one shared 32x32 multiplier: one pass for the square and two passes
//  per weighted update of the five step averages and the interval average.
//  A new request word is taken the cycle after the response is loaded, even
//  while that response still waits on rsp_stall; the next response then waits
//  in the sequencer until the output register is free.
//  Reset (synchronous) clears all statistics and drops any pending response.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module correction_step_statistics #(
   parameter int FRAC_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_pwm,
   input  logic               req_counting,
   input  logic [31:0]        req_time_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [47:0]        rsp_mean_sq_100,
   output logic [47:0]        rsp_mean_sq_1k,
   output logic [47:0]        rsp_mean_sq_10k,
   output logic [47:0]        rsp_mean_sq_100k,
   output logic signed [32:0] rsp_mean_step,
   output logic [15:0]        rsp_peak_step,
   output logic [31:0]        rsp_update_count,
   output logic [31:0]        rsp_gated_count,
   output logic [27:0]        rsp_interval_ms
);

   localparam int SH     = FRAC_BITS - 16;
   localparam int SQ_W   = 32 + FRAC_BITS;
   localparam int STEP_W = 18 + FRAC_BITS;
   localparam int MAG_W  = SQ_W;
   localparam int DW     = SQ_W + 1;

   csst_pkg::seq_state_type    state_ff, state_in;
   csst_pkg::op_type           op_ff, op_in;
   csst_pkg::scale_cmd_type    scale_cmd;
   csst_pkg::scale_status_type scale_status;
   logic [MAG_W-1:0]           scale_result;
   logic [31:0]                scale_weight;
   logic                       out_load;

   // Latched request word and per-word working values.
   logic [15:0]               pwm_ff;
   logic [31:0]               time_ff;
   logic signed [16:0]        d_ff;
   logic [15:0]               ad_ff;
   logic [31:0]               sq_ff;
   logic [27:0]               ivl_t_ff;
   logic [MAG_W-1:0]          mag_ff;
   logic                      neg_ff;
   logic                      do_ivl_ff;

   // Statistics state.
   logic [15:0]               prev_word_ff;
   logic                      prev_valid_ff;
   logic [SQ_W-1:0]           sq100_ff, sq1k_ff, sq10k_ff, sq100k_ff;
   logic signed [STEP_W-1:0]  step_avg_ff;
   logic [15:0]               largest_step_ff;
   logic [31:0]               steps_seen_ff;
   logic [31:0]               gated_ff;
   logic [31:0]               last_stamp_ff;
   logic                      stamp_valid_ff;
   logic [27:0]               ivl_ff;

   // Output register.
   logic                      rsp_valid_ff;
   logic [47:0]               rsp_sq100_ff, rsp_sq1k_ff, rsp_sq10k_ff, rsp_sq100k_ff;
   logic signed [32:0]        rsp_step_ff;
   logic [15:0]               rsp_peak_ff;
   logic [31:0]               rsp_count_ff;
   logic [31:0]               rsp_gated_ff;
   logic [27:0]               rsp_ivl_ff;

   // Combinational values.
   logic [31:0]               gap;
   logic                      ivl_go;
   logic [27:0]               ivl_t;
   logic signed [16:0]        d;
   logic [15:0]               ad;
   logic signed [DW-1:0]      avg_sel, tgt_sel, diff, res_ext, sum;
   logic [MAG_W-1:0]          mag_c;
   logic                      accept;

   assign accept = (state_ff == csst_pkg::ST_IDLE) && req_valid;

   // Interval gap and step of the latched word.
   assign gap    = time_ff - last_stamp_ff;
   assign ivl_go = stamp_valid_ff && (gap != 32'd0) && (gap < csst_pkg::GAP_LIMIT_MS);
   assign ivl_t  = 28'(gap << csst_pkg::IVL_FRAC);
   assign d      = $signed({1'b0, pwm_ff}) - $signed({1'b0, prev_word_ff});
   assign ad     = d[16] ? 16'(-d) : d[15:0];

   // Current average and its target, both widened to the working width.
   always_comb begin
      case (op_ff)
         csst_pkg::OP_SQ100:  avg_sel = $signed({1'b0, sq100_ff});
         csst_pkg::OP_SQ1K:   avg_sel = $signed({1'b0, sq1k_ff});
         csst_pkg::OP_SQ10K:  avg_sel = $signed({1'b0, sq10k_ff});
         csst_pkg::OP_SQ100K: avg_sel = $signed({1'b0, sq100k_ff});
         csst_pkg::OP_STEP:   avg_sel = DW'(step_avg_ff);
         csst_pkg::OP_IVL:    avg_sel = $signed({{(DW-28){1'b0}}, ivl_ff});
         default:             avg_sel = '0;
      endcase
      case (op_ff)
         csst_pkg::OP_STEP: tgt_sel = $signed({{(DW-17-FRAC_BITS){d_ff[16]}}, d_ff,
                                               {FRAC_BITS{1'b0}}});
         csst_pkg::OP_IVL:  tgt_sel = $signed({{(DW-28){1'b0}}, ivl_t_ff});
         default:           tgt_sel = $signed({1'b0, sq_ff, {FRAC_BITS{1'b0}}});
      endcase
   end

   // Difference and its magnitude; the scaled magnitude is added back with its sign.
   assign diff    = tgt_sel - avg_sel;
   assign mag_c   = diff[DW-1] ? MAG_W'(-diff) : MAG_W'(diff);
   assign res_ext = $signed({1'b0, scale_result});
   assign sum     = neg_ff ? (avg_sel - res_ext) : (avg_sel + res_ext);

   // Weight for the scaler: the step itself for the square, else the average's weight.
   always_comb begin
      if (state_ff == csst_pkg::ST_SQ_GO) begin
         scale_weight = {16'h0000, ad_ff};
      end else begin
         case (op_ff)
            csst_pkg::OP_SQ100:  scale_weight = csst_pkg::W_100;
            csst_pkg::OP_SQ1K:   scale_weight = csst_pkg::W_1K;
            csst_pkg::OP_SQ10K:  scale_weight = csst_pkg::W_10K;
            csst_pkg::OP_SQ100K: scale_weight = csst_pkg::W_100K;
            csst_pkg::OP_STEP:   scale_weight = csst_pkg::W_100K;
            csst_pkg::OP_IVL:    scale_weight = csst_pkg::W_005;
            default:             scale_weight = '0;
         endcase
      end
   end

   // Sequencer: next state and control outputs.
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      scale_cmd       = '0;
      out_load        = 1'b0;
      req_stall       = (state_ff != csst_pkg::ST_IDLE);
      case (state_ff)
         csst_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = req_counting ? csst_pkg::ST_START : csst_pkg::ST_OUT;
            end
         end
         csst_pkg::ST_START: begin
            if (prev_valid_ff) begin
               state_in = csst_pkg::ST_SQ_GO;
            end else if (ivl_go && (ivl_ff != 28'd0)) begin
               op_in    = csst_pkg::OP_IVL;
               state_in = csst_pkg::ST_DIFF;
            end else begin
               state_in = csst_pkg::ST_OUT;
            end
         end
         csst_pkg::ST_SQ_GO: begin
            scale_cmd.start  = 1'b1;
            scale_cmd.square = 1'b1;
            state_in         = csst_pkg::ST_SQ_WAIT;
         end
         csst_pkg::ST_SQ_WAIT: begin
            if (scale_status.done) begin
               op_in    = csst_pkg::OP_SQ100;
               state_in = csst_pkg::ST_DIFF;
            end
         end
         csst_pkg::ST_DIFF: begin
            state_in = csst_pkg::ST_GO;
         end
         csst_pkg::ST_GO: begin
            scale_cmd.start = 1'b1;
            state_in        = csst_pkg::ST_WAIT;
         end
         csst_pkg::ST_WAIT: begin
            if (scale_status.done) begin
               state_in = csst_pkg::ST_DIFF;
               case (op_ff)
                  csst_pkg::OP_SQ100:  op_in = csst_pkg::OP_SQ1K;
                  csst_pkg::OP_SQ1K:   op_in = csst_pkg::OP_SQ10K;
                  csst_pkg::OP_SQ10K:  op_in = csst_pkg::OP_SQ100K;
                  csst_pkg::OP_SQ100K: op_in = csst_pkg::OP_STEP;
                  csst_pkg::OP_STEP: begin
                     if (do_ivl_ff) op_in = csst_pkg::OP_IVL;
                     else state_in = csst_pkg::ST_OUT;
                  end
                  default: begin
                     state_in = csst_pkg::ST_OUT;
                  end
               endcase
            end
         end
         csst_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = csst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csst_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer registers and statistics state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= csst_pkg::ST_IDLE;
         op_ff           <= csst_pkg::OP_SQ100;
         do_ivl_ff       <= 1'b0;
         prev_word_ff    <= '0;
         prev_valid_ff   <= 1'b0;
         sq100_ff        <= '0;
         sq1k_ff         <= '0;
         sq10k_ff        <= '0;
         sq100k_ff       <= '0;
         step_avg_ff     <= '0;
         largest_step_ff <= '0;
         steps_seen_ff   <= '0;
         gated_ff        <= '0;
         last_stamp_ff   <= '0;
         stamp_valid_ff  <= 1'b0;
         ivl_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;

         // A closed gate forgets the previous word and stamp.
         if (accept && !req_counting) begin
            prev_valid_ff  <= 1'b0;
            stamp_valid_ff <= 1'b0;
            gated_ff       <= gated_ff + 32'd1;
         end

         // Stamp, interval load, previous word, peak and count.
         if (state_ff == csst_pkg::ST_START) begin
            last_stamp_ff  <= time_ff;
            stamp_valid_ff <= 1'b1;
            do_ivl_ff      <= ivl_go && (ivl_ff != 28'd0);
            if (ivl_go && (ivl_ff == 28'd0)) ivl_ff <= ivl_t;
            prev_word_ff  <= pwm_ff;
            prev_valid_ff <= 1'b1;
            if (prev_valid_ff) begin
               if ((ad > largest_step_ff) && (ad < csst_pkg::STEP_LIMIT)) begin
                  largest_step_ff <= ad;
               end
               if (steps_seen_ff < csst_pkg::COUNT_MAX) begin
                  steps_seen_ff <= steps_seen_ff + 32'd1;
               end
            end
         end

         // Write back the updated average.
         if ((state_ff == csst_pkg::ST_WAIT) && scale_status.done) begin
            case (op_ff)
               csst_pkg::OP_SQ100:  sq100_ff    <= SQ_W'(sum);
               csst_pkg::OP_SQ1K:   sq1k_ff     <= SQ_W'(sum);
               csst_pkg::OP_SQ10K:  sq10k_ff    <= SQ_W'(sum);
               csst_pkg::OP_SQ100K: sq100k_ff   <= SQ_W'(sum);
               csst_pkg::OP_STEP:   step_avg_ff <= STEP_W'(sum);
               csst_pkg::OP_IVL:    ivl_ff      <= 28'(sum);
               default: begin
               end
            endcase
         end

         // Response valid: set on load, cleared once taken.
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         pwm_ff  <= req_pwm;
         time_ff <= req_time_ms;
      end
      if (state_ff == csst_pkg::ST_START) begin
         d_ff     <= d;
         ad_ff    <= ad;
         ivl_t_ff <= ivl_t;
         mag_ff   <= MAG_W'(ad);
      end
      if ((state_ff == csst_pkg::ST_SQ_WAIT) && scale_status.done) begin
         sq_ff <= scale_result[31:0];
      end
      if (state_ff == csst_pkg::ST_DIFF) begin
         mag_ff <= mag_c;
         neg_ff <= diff[DW-1];
      end
      if (out_load) begin
         rsp_sq100_ff  <= 48'(sq100_ff >> SH);
         rsp_sq1k_ff   <= 48'(sq1k_ff >> SH);
         rsp_sq10k_ff  <= 48'(sq10k_ff >> SH);
         rsp_sq100k_ff <= 48'(sq100k_ff >> SH);
         rsp_step_ff   <= 33'(step_avg_ff >>> SH);
         rsp_peak_ff   <= largest_step_ff;
         rsp_count_ff  <= steps_seen_ff;
         rsp_gated_ff  <= gated_ff;
         rsp_ivl_ff    <= ivl_ff;
      end
   end

   // Shared multiplier unit.
   csst_scaler #(
      .MAG_W (MAG_W)
   ) u_scaler (
      .clock      (clock),
      .reset      (reset),
      .cmd        (scale_cmd),
      .cmd_mag    (mag_ff),
      .cmd_weight (scale_weight),
      .status     (scale_status),
      .result     (scale_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_sq_100  = rsp_sq100_ff;
   assign rsp_mean_sq_1k   = rsp_sq1k_ff;
   assign rsp_mean_sq_10k  = rsp_sq10k_ff;
   assign rsp_mean_sq_100k = rsp_sq100k_ff;
   assign rsp_mean_step    = rsp_step_ff;
   assign rsp_peak_step    = rsp_peak_ff;
   assign rsp_update_count = rsp_count_ff;
   assign rsp_gated_count  = rsp_gated_ff;
   assign rsp_interval_ms  = rsp_ivl_ff;

   // A gated word goes straight to the output stage.
   `ASSERT_NEXT(a_gated_out, clock, reset, accept && !req_counting, state_ff == csst_pkg::ST_OUT, "gated word not sent out")
   // The scaler is never started while it is still busy.
   `ASSERT_IMPL(a_start_idle, clock, reset, scale_cmd.start, !scale_status.busy, "scaler started while busy")
   // The step count never goes backward.
   `ASSERT_IMPL(a_count_rising, clock, reset, !$past(reset), steps_seen_ff >= $past(steps_seen_ff), "step count decreased")
   // The full-scale step never becomes the peak.
   `ASSERT_ALWAYS(a_peak_limit, clock, reset, largest_step_ff != csst_pkg::STEP_LIMIT, "peak hit step limit")

endmodule
